FILE: rtl/assert_macros.svh
// Assertion macros shared by the list RTL.
// Depends on a clock named clock and a synchronous reset named reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// implication: antecedent |-> consequent
`define ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// next-cycle implication: antecedent |=> consequent
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/idl_pkg.sv
// Package for the indexed deque list: sizes, command and status codes,
// transfer payload structs and the per-cell command struct. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package idl_pkg;

   localparam int DEPTH  = 16;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int POS_W  = 8;
   localparam int DATA_W = 32;
   localparam int CMP_W  = (POS_W + 1 > CNT_W) ? POS_W + 1 : CNT_W;

   typedef enum logic [2:0] {
      ACT_PUSH_BACK   = 3'd0,
      ACT_POP_BACK    = 3'd1,
      ACT_PUSH_FRONT  = 3'd2,
      ACT_SET_SINGLE  = 3'd3,
      ACT_INSERT_AFTER = 3'd4,
      ACT_REMOVE_AT   = 3'd5
   } action_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_REMOVE = 2'd2,
      CELL_SET    = 2'd3
   } cell_mode_type;

   typedef struct packed {
      logic [2:0]               action;
      logic [POS_W-1:0]         position;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] data_out;
      logic [1:0]               status;
      logic [8:0]               count;
   } rsp_type;

   typedef struct packed {
      cell_mode_type       mode;
      logic [CNT_W-1:0]    at;
      logic [CNT_W-1:0]    count;
      logic [DATA_W-1:0]   value;
   } cell_cmd_type;

endpackage

`default_nettype wire

FILE: rtl/idl_cell.sv
// One storage cell of the list: holds one entry and shifts with its neighbors.
// Depends on idl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module idl_cell
   import idl_pkg::*;
(
   input  wire logic              clock,
   input  wire logic [CNT_W-1:0]  cell_idx,
   input  wire cell_cmd_type      cmd,
   input  wire logic [DATA_W-1:0] left_data,
   input  wire logic [DATA_W-1:0] right_data,
   output logic [DATA_W-1:0]      data
);

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;
   logic [CNT_W:0]    idx_next;

   assign idx_next = {1'b0, cell_idx} + 1'b1;

   always_comb begin
      data_in = data_ff;
      case (cmd.mode)
         CELL_INSERT: begin
            if (cell_idx == cmd.at) begin
               data_in = cmd.value;
            end else if (cell_idx > cmd.at && cell_idx <= cmd.count) begin
               data_in = left_data;
            end
         end
         CELL_REMOVE: begin
            if (cell_idx >= cmd.at && idx_next < {1'b0, cmd.count}) begin
               data_in = right_data;
            end
         end
         CELL_SET: begin
            if (cell_idx == '0) begin
               data_in = cmd.value;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   // entry payload carries no reset
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

`default_nettype wire

FILE: rtl/idl_obuf.sv
// Result register with a skid stage between the list and the result channel.
// Depends on idl_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module idl_obuf
   import idl_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    load,
   input  wire rsp_type load_rsp,
   output logic         full,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp
);

   logic    out_valid_ff, out_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type out_ff, out_in;
   rsp_type skid_ff, skid_in;
   logic    out_take;

   assign out_take = out_valid_ff && !rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (out_take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (load) begin
         if (!out_valid_ff || out_take) begin
            out_in       = load_rsp;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = load_rsp;
            skid_valid_in = 1'b1;
         end
      end else if (out_take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign full      = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp       = out_ff;

   `ASSERT_IMPL(a_skid_behind_out, skid_valid_ff, out_valid_ff, "skid valid, output empty")
   `ASSERT_NEXT(a_skid_drains, skid_valid_ff && out_take, !skid_valid_ff && out_valid_ff, "no drain")

endmodule

`default_nettype wire

FILE: rtl/indexed_deque_list.sv
// Indexed deque list: a bounded ordered list of signed 32-bit entries.
// Request channel (req_valid / req_stall / req): one command per transfer,
// action = push back, pop back, push front, set single, insert after or
// remove at, with position and value. Result channel (rsp_valid / rsp_stall
// / rsp): exactly one result per command, in order: data_out, status, count.
// Each result is registered in the output register, or in the skid stage.
// Throughput: one command per cycle while req_stall is low; the list is a row
// of DEPTH cells that each shift left, shift right, load the value or hold in
// the same cycle the command is accepted, so the next command sees the updated list.
// The result path has an output register and a one-entry skid stage; the
// request side stalls only when both are full, i.e. once another command was
// transferred while a shown result was stalled.
// Reset (synchronous, active high) empties the list and drops any pending
// result; entries themselves are not cleared and are never read unwritten.
// Depends on idl_pkg, idl_cell, idl_obuf and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module indexed_deque_list
   import idl_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp
);

   logic [CNT_W-1:0]  count_ff, count_in;
   logic              req_accept;
   logic              list_full;
   logic [CMP_W-1:0]  pos_ext, cnt_ext, ins_ext;
   cell_cmd_type      cmd;
   logic [CNT_W-1:0]  rd_at;
   logic              rd_en;
   logic [DATA_W-1:0] cell_data [DEPTH];
   logic [DATA_W-1:0] rd_data;
   status_type        status;
   rsp_type           new_rsp;
   logic              obuf_full;

   assign req_stall  = obuf_full;
   assign req_accept = req_valid && !req_stall;
   assign list_full  = (count_ff == CNT_W'(DEPTH));

   assign pos_ext = CMP_W'(req.position);
   assign cnt_ext = CMP_W'(count_ff);
   assign ins_ext = (pos_ext + 1'b1 > cnt_ext) ? cnt_ext : pos_ext + 1'b1;

   always_comb begin
      cmd.mode  = CELL_HOLD;
      cmd.at    = '0;
      cmd.count = count_ff;
      cmd.value = req.value;
      count_in  = count_ff;
      status    = ST_OK;
      rd_at     = '0;
      rd_en     = 1'b0;
      case (action_type'(req.action))
         ACT_PUSH_BACK: begin
            if (list_full) begin
               status = ST_FULL;
            end else begin
               cmd.mode = CELL_INSERT;
               cmd.at   = count_ff;
               count_in = count_ff + 1'b1;
            end
         end
         ACT_POP_BACK: begin
            if (count_ff == '0) begin
               status = ST_EMPTY;
            end else begin
               cmd.mode = CELL_REMOVE;
               cmd.at   = count_ff - 1'b1;
               rd_at    = count_ff - 1'b1;
               rd_en    = 1'b1;
               count_in = count_ff - 1'b1;
            end
         end
         ACT_PUSH_FRONT: begin
            if (list_full) begin
               status = ST_FULL;
            end else begin
               cmd.mode = CELL_INSERT;
               cmd.at   = '0;
               count_in = count_ff + 1'b1;
            end
         end
         ACT_SET_SINGLE: begin
            cmd.mode = CELL_SET;
            count_in = CNT_W'(1);
         end
         ACT_INSERT_AFTER: begin
            if (list_full) begin
               status = ST_FULL;
            end else begin
               cmd.mode = CELL_INSERT;
               cmd.at   = ins_ext[CNT_W-1:0];
               count_in = count_ff + 1'b1;
            end
         end
         ACT_REMOVE_AT: begin
            if (pos_ext >= cnt_ext) begin
               status = ST_EMPTY;
            end else begin
               cmd.mode = CELL_REMOVE;
               cmd.at   = pos_ext[CNT_W-1:0];
               rd_at    = pos_ext[CNT_W-1:0];
               rd_en    = 1'b1;
               count_in = count_ff - 1'b1;
            end
         end
         default: begin
            status = ST_OK;
         end
      endcase
      if (!req_accept) begin
         cmd.mode = CELL_HOLD;
         count_in = count_ff;
      end
   end

   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         logic [DATA_W-1:0] left_data;
         logic [DATA_W-1:0] right_data;
         if (gi == 0) begin : g_first
            assign left_data = '0;
         end else begin : g_mid_l
            assign left_data = cell_data[gi-1];
         end
         if (gi == DEPTH - 1) begin : g_last
            assign right_data = '0;
         end else begin : g_mid_r
            assign right_data = cell_data[gi+1];
         end
         idl_cell u_cell (
            .clock      (clock),
            .cell_idx   (CNT_W'(gi)),
            .cmd        (cmd),
            .left_data  (left_data),
            .right_data (right_data),
            .data       (cell_data[gi])
         );
      end
   endgenerate

   assign rd_data = rd_en ? cell_data[rd_at[IDX_W-1:0]] : '0;

   assign new_rsp.data_out = rd_data;
   assign new_rsp.status   = status;
   assign new_rsp.count    = 9'(count_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   idl_obuf u_obuf (
      .clock     (clock),
      .reset     (reset),
      .load      (req_accept),
      .load_rsp  (new_rsp),
      .full      (obuf_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   `ASSERT_ALWAYS(a_count_bound, count_ff <= CNT_W'(DEPTH), "entry count beyond depth")
   `ASSERT_NEXT(a_rsp_follows, req_accept, rsp_valid, "no result after accepted command")
   `ASSERT_NEXT(a_full_add_holds, req_accept && status == ST_FULL, $stable(count_ff), "count moved")
   `ASSERT_IMPL(a_idle_holds, !req_accept, count_in == count_ff, "count moved without a transfer")

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for indexed_deque_list: directed and random commands
// are checked against a queue-based shadow of the list. Depends on idl_pkg.

module tb_top
   import idl_pkg::*;
();

   localparam logic [2:0] ACT_SPARE_A   = 3'd6;
   localparam logic [2:0] ACT_SPARE_B   = 3'd7;
   localparam int         RANDOM_CMDS   = 2000;
   localparam int         PRESS_START   = 400;
   localparam int         PRESS_LEN     = 120;
   localparam int         HOLD_CYCLES   = 80;
   localparam int         IDLE_LIMIT    = 1000;
   localparam int         PRINT_LIMIT   = 20;

   class deque_shadow;
      logic [DATA_W-1:0] cells[$];
      rsp_type           answers_due[$];
      int                mismatches;
      int                checked;
      int                full_answers;
      int                empty_answers;
      int                peak_fill;

      function new();
         mismatches    = 0;
         checked       = 0;
         full_answers  = 0;
         empty_answers = 0;
         peak_fill     = 0;
      endfunction

      function rsp_type apply_command(req_type c);
         rsp_type r;
         int      at;
         r = '0;
         r.status = ST_OK;
         case (c.action)
            ACT_PUSH_BACK: begin
               if (cells.size() >= DEPTH) r.status = ST_FULL;
               else cells.push_back(c.value);
            end
            ACT_POP_BACK: begin
               if (cells.size() == 0) r.status = ST_EMPTY;
               else r.data_out = cells.pop_back();
            end
            ACT_PUSH_FRONT: begin
               if (cells.size() >= DEPTH) r.status = ST_FULL;
               else cells.push_front(c.value);
            end
            ACT_SET_SINGLE: begin
               cells.delete();
               cells.push_back(c.value);
            end
            ACT_INSERT_AFTER: begin
               if (cells.size() >= DEPTH) begin
                  r.status = ST_FULL;
               end else begin
                  at = int'(c.position) + 1;
                  if (at > cells.size()) at = cells.size();
                  cells.insert(at, c.value);
               end
            end
            ACT_REMOVE_AT: begin
               if (int'(c.position) >= cells.size()) begin
                  r.status = ST_EMPTY;
               end else begin
                  r.data_out = cells[c.position];
                  cells.delete(c.position);
               end
            end
            default: ;
         endcase
         r.count = 9'(cells.size());
         return r;
      endfunction

      function void note_command(req_type c);
         rsp_type r;
         r = apply_command(c);
         if (r.status == ST_FULL) full_answers++;
         if (r.status == ST_EMPTY) empty_answers++;
         if (cells.size() > peak_fill) peak_fill = cells.size();
         answers_due.push_back(r);
      endfunction

      task report_mismatch(string msg);
         mismatches++;
         if (mismatches <= PRINT_LIMIT) $display("[%0t] mismatch: %s", $time, msg);
      endtask

      task check_answer(rsp_type got);
         rsp_type exp;
         if (answers_due.size() == 0) begin
            report_mismatch("result with no command outstanding");
         end else begin
            exp = answers_due.pop_front();
            checked++;
            if (got.data_out !== exp.data_out)
               report_mismatch($sformatf("data_out %h, expected %h", got.data_out,
                                         exp.data_out));
            if (got.status !== exp.status)
               report_mismatch($sformatf("status %0d, expected %0d", got.status,
                                         exp.status));
            if (got.count !== exp.count)
               report_mismatch($sformatf("count %0d, expected %0d", got.count, exp.count));
         end
      endtask
   endclass

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req       = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp;

   deque_shadow shadow  = new();
   int          accepted_cmds = 0;
   int          idle_cycles   = 0;
   bit          hold_done     = 1'b0;

   indexed_deque_list u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) shadow.check_answer(rsp);
         if (req_valid && !req_stall) begin
            shadow.note_command(req);
            accepted_cmds++;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("[%0t] no transfer for %0d cycles", $time, IDLE_LIMIT);
         $display("end of test: mismatches");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 30);
   endfunction

   function automatic req_type make_cmd(logic [2:0] act, logic [POS_W-1:0] pos,
                                        logic [DATA_W-1:0] val);
      req_type c;
      c.action   = act;
      c.position = pos;
      c.value    = val;
      return c;
   endfunction

   function automatic req_type random_command(bit growing);
      int                r;
      logic [2:0]        act;
      logic [POS_W-1:0]  pos;
      logic [DATA_W-1:0] val;
      r = $urandom_range(0, 99);
      if (r < 3)                     act = $urandom_range(0, 1) ? ACT_SPARE_A : ACT_SPARE_B;
      else if (r < 7)                act = ACT_SET_SINGLE;
      else if (r < (growing ? 29 : 17)) act = ACT_PUSH_BACK;
      else if (r < (growing ? 47 : 24)) act = ACT_PUSH_FRONT;
      else if (r < (growing ? 71 : 31)) act = ACT_INSERT_AFTER;
      else if (r < (growing ? 86 : 62)) act = ACT_POP_BACK;
      else                           act = ACT_REMOVE_AT;
      if ($urandom_range(0, 3) != 0) pos = POS_W'($urandom_range(0, DEPTH + 1));
      else                           pos = POS_W'($urandom_range(0, 255));
      case ($urandom_range(0, 19))
         0:       val = 32'h8000_0000;
         1:       val = 32'h7FFF_FFFF;
         2:       val = 32'hFFFF_FFFF;
         3:       val = 32'h0000_0000;
         default: val = $urandom;
      endcase
      return make_cmd(act, pos, val);
   endfunction

   task automatic issue_command(input req_type c, input int gap);
      @(negedge clock);
      req       <= c;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // receiver: random stalls, quiet stretches, and one long hold-off
   initial begin
      int r;
      int len;
      forever begin
         @(negedge clock);
         if (!hold_done && accepted_cmds >= PRESS_START) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_done = 1'b1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
               rsp_stall <= 1'b0;
               len = $urandom_range(1, 4);
            end else if (r < 85) begin
               rsp_stall <= 1'b1;
               len = $urandom_range(1, 3);
            end else if (r < 93) begin
               rsp_stall <= 1'b1;
               len = $urandom_range(8, 30);
            end else begin
               rsp_stall <= 1'b0;
               len = $urandom_range(40, 80);
            end
            repeat (len - 1) @(negedge clock);
         end
      end
   end

   initial begin
      int  gap;
      int  phase_left;
      bit  growing;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      issue_command(make_cmd(ACT_POP_BACK, 8'd0, 32'h1234_5678), pick_gap());
      issue_command(make_cmd(ACT_REMOVE_AT, 8'd255, 32'h0), pick_gap());
      issue_command(make_cmd(ACT_INSERT_AFTER, 8'd255, 32'h8000_0000), pick_gap());
      issue_command(make_cmd(ACT_PUSH_FRONT, 8'd0, 32'h7FFF_FFFF), pick_gap());
      issue_command(make_cmd(ACT_PUSH_BACK, 8'd0, 32'hFFFF_FFFF), pick_gap());
      issue_command(make_cmd(ACT_INSERT_AFTER, 8'd0, 32'h0), pick_gap());
      issue_command(make_cmd(ACT_REMOVE_AT, 8'd4, 32'h0), pick_gap());
      issue_command(make_cmd(ACT_SPARE_A, 8'hFF, 32'hFFFF_FFFF), pick_gap());
      issue_command(make_cmd(ACT_SPARE_B, 8'hFF, 32'hFFFF_FFFF), pick_gap());
      issue_command(make_cmd(ACT_REMOVE_AT, 8'd1, 32'h0), pick_gap());
      issue_command(make_cmd(ACT_POP_BACK, 8'd0, 32'h0), pick_gap());
      for (int i = 0; i < DEPTH - 2; i++) begin
         case (i % 3)
            0:       issue_command(make_cmd(ACT_PUSH_BACK, 8'd0, $urandom), pick_gap());
            1:       issue_command(make_cmd(ACT_PUSH_FRONT, 8'd0, $urandom), pick_gap());
            default: issue_command(make_cmd(ACT_INSERT_AFTER,
                                            POS_W'($urandom_range(0, DEPTH)),
                                            $urandom), pick_gap());
         endcase
      end
      issue_command(make_cmd(ACT_PUSH_BACK, 8'd0, 32'h5555_AAAA), pick_gap());
      issue_command(make_cmd(ACT_PUSH_FRONT, 8'd0, 32'hAAAA_5555), pick_gap());
      issue_command(make_cmd(ACT_INSERT_AFTER, 8'd3, 32'h0F0F_F0F0), pick_gap());
      issue_command(make_cmd(ACT_REMOVE_AT, POS_W'(DEPTH - 1), 32'h0), pick_gap());
      issue_command(make_cmd(ACT_SET_SINGLE, 8'd0, 32'h8000_0001), pick_gap());

      growing    = 1'b1;
      phase_left = $urandom_range(64, 160);
      for (int n = 0; n < RANDOM_CMDS; n++) begin
         if (phase_left == 0) begin
            growing    = !growing;
            phase_left = $urandom_range(64, 160);
         end
         phase_left--;
         if (accepted_cmds >= PRESS_START && accepted_cmds < PRESS_START + PRESS_LEN)
            gap = 0;
         else
            gap = pick_gap();
         issue_command(random_command(growing), gap);
      end
      @(negedge clock);
      req_valid <= 1'b0;

      while (shadow.answers_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("%0d commands, %0d results checked; list peaked at %0d entries",
               accepted_cmds, shadow.checked, shadow.peak_fill);
      $display("%0d adds refused on a full list, %0d takes refused on empty or bad index",
               shadow.full_answers, shadow.empty_answers);
      if (shadow.mismatches == 0 && shadow.answers_due.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
